@@ design/indexed_min_heap_queue_unit_assert.svh @@
// assertion macros for the indexed min-heap queue unit
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// a property that must hold at every edge outside reset
`define IMHQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// an implication that must hold at every edge outside reset
`define IMHQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/imhq_pkg.sv @@
// shared types and constants for the indexed min-heap queue unit
package imhq_pkg;

    localparam int HEAP_DEPTH_DEF   = 256;
    localparam int VERTEX_COUNT_DEF = 256;
    localparam int WEIGHT_BITS_DEF  = 32;

    localparam int KIND_W   = 3;
    localparam int VERTEX_W = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT   = 3'd0,
        K_DECREASE = 3'd1,
        K_EXTRACT  = 3'd2,
        K_DELETE   = 3'd3,
        K_LOOKUP   = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_IGNORED  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_POS,       // read vertex-to-slot entry
        S_RD_SLOT,      // read slot at r_idx
        S_DECIDE,       // act on the request
        S_UP_RD,        // read parent
        S_UP_CMP,       // compare with parent, swap
        S_UP_WR_ENTRY,  // write the moving entry at its new slot
        S_DN_RDL,       // read left child
        S_DN_RDR,       // read right child
        S_DN_CMP,       // choose and swap
        S_LAST_RD,      // read last slot on removal
        S_LAST_WR,      // move last into hole
        S_OUT           // present the result
    } t_state;

endpackage

@@ design/indexed_min_heap_queue_unit.sv @@
// indexed min-heap queue: top level with sequencer and heap memories
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+-------------------------------------------
//  request | i_valid    | o_stall    | i_kind, i_vertex_id, i_new_weight
//  result  | o_valid    | i_stall    | o_status, o_out_vertex, o_out_weight, ...
//  config  | i_cfg_we   | -          | i_cfg_data (capacity_limit)
//
// one request at a time; each request walks the single-port slot memory with one weight
// comparator, one slot access at a time, through sift up, sift down and, on removal,
// the move of the last entry into the hole.
// reset is synchronous and clears the presence flags at once; no clearing pass.
// a result waits in the output register while i_stall is high; the next request
// is taken after that result transfers.
module indexed_min_heap_queue_unit #(
    parameter int HEAP_DEPTH   = imhq_pkg::HEAP_DEPTH_DEF,
    parameter int VERTEX_COUNT = imhq_pkg::VERTEX_COUNT_DEF,
    parameter int WEIGHT_BITS  = imhq_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [imhq_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [imhq_pkg::KIND_W-1:0]   i_kind,
    input  logic [imhq_pkg::VERTEX_W-1:0] i_vertex_id,
    input  logic [WEIGHT_BITS-1:0]        i_new_weight,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [imhq_pkg::STATUS_W-1:0] o_status,
    output logic [imhq_pkg::VERTEX_W-1:0] o_out_vertex,
    output logic [WEIGHT_BITS-1:0]        o_out_weight,
    output logic                          o_is_present,
    output logic [imhq_pkg::COUNT_W-1:0]  o_entry_count
);
    import imhq_pkg::*;
    `include "indexed_min_heap_queue_unit_assert.svh"

    localparam int SW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int NW = $clog2(HEAP_DEPTH + 1);
    localparam int VW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int IW = NW + 1;   // slot index wide enough for child arithmetic
    localparam int HW = (COUNT_W > NW) ? COUNT_W : NW;

    // heap memories: slot -> (vertex, weight), vertex -> slot
    logic [VERTEX_W-1:0]    m_svert [HEAP_DEPTH];
    logic [WEIGHT_BITS-1:0] m_swgt  [HEAP_DEPTH];
    logic [SW-1:0]          m_vslot [VERTEX_COUNT];
    logic [VERTEX_COUNT-1:0] r_present;

    // slot memory port
    logic                   s_we;
    logic [SW-1:0]          s_addr;
    logic [VERTEX_W-1:0]    s_wv;
    logic [WEIGHT_BITS-1:0] s_ww;
    logic [VERTEX_W-1:0]    r_rd_v;
    logic [WEIGHT_BITS-1:0] r_rd_w;
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            m_svert[s_addr] <= s_wv;
            m_swgt[s_addr]  <= s_ww;
        end
        r_rd_v <= m_svert[s_addr];
        r_rd_w <= m_swgt[s_addr];
    end

    // position memory port
    logic          p_we;
    logic [VW-1:0] p_addr;
    logic [SW-1:0] p_wd;
    logic [SW-1:0] r_pos;
    always_ff @(posedge i_clk) begin
        if (p_we) m_vslot[p_addr] <= p_wd;
        r_pos <= m_vslot[p_addr];
    end

    // sequencer registers
    t_state                 r_state, n_state;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [VERTEX_W-1:0]    r_vid, n_vid;
    logic [WEIGHT_BITS-1:0] r_nw, n_nw;
    logic                   r_inr, n_inr;
    logic [IW-1:0]          r_idx, n_idx;    // current slot
    logic [IW-1:0]          r_oth, n_oth;    // parent or chosen child
    logic [VERTEX_W-1:0]    r_cv, n_cv;      // entry being sifted
    logic [WEIGHT_BITS-1:0] r_cw, n_cw;
    logic [VERTEX_W-1:0]    r_lv, n_lv;      // left child
    logic [WEIGHT_BITS-1:0] r_lw, n_lw;
    logic [NW-1:0]          r_fill, n_fill;
    logic [COUNT_W-1:0]     r_cap;
    logic                   r_ov, n_ov;
    logic [STATUS_W-1:0]    r_st, n_st;
    logic [VERTEX_W-1:0]    r_ovx, n_ovx;
    logic [WEIGHT_BITS-1:0] r_ow, n_ow;
    logic                   r_op, n_op;
    logic                   r_dn;            // sifting down
    logic                   pr_we, pr_set;
    logic [VW-1:0]          pr_addr;
    logic [IW-1:0]          last_i, lidx, ridx, pidx;
    logic                   cap_full, cur_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_cap     <= COUNT_W'(256);
            r_present <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ov    <= n_ov;
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (pr_we) r_present[pr_addr] <= pr_set;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_vid <= n_vid; r_nw <= n_nw; r_inr <= n_inr;
        r_idx <= n_idx; r_oth <= n_oth; r_cv <= n_cv; r_cw <= n_cw;
        r_lv <= n_lv; r_lw <= n_lw; r_st <= n_st; r_ovx <= n_ovx;
        r_ow <= n_ow; r_op <= n_op;
    end

    assign last_i = IW'(r_fill) - IW'(1);
    assign lidx   = {r_idx[IW-2:0], 1'b1};
    assign ridx   = lidx + IW'(1);
    assign pidx   = (r_idx - IW'(1)) >> 1;
    // capacity saturates at the heap depth
    assign cap_full = (HW'(r_fill) >= HW'(r_cap)) || (HW'(r_fill) >= HW'(HEAP_DEPTH));
    assign cur_present = r_inr && r_present[r_vid[VW-1:0]];

    // next state and memory control
    always_comb begin
        n_state = r_state; n_kind = r_kind; n_vid = r_vid; n_nw = r_nw;
        n_inr = r_inr; n_idx = r_idx; n_oth = r_oth; n_cv = r_cv; n_cw = r_cw;
        n_lv = r_lv; n_lw = r_lw; n_fill = r_fill; n_ov = r_ov; n_st = r_st;
        n_ovx = r_ovx; n_ow = r_ow; n_op = r_op;
        s_we = 1'b0; s_addr = r_idx[SW-1:0]; s_wv = r_cv; s_ww = r_cw;
        p_we = 1'b0; p_addr = r_vid[VW-1:0]; p_wd = r_idx[SW-1:0];
        pr_we = 1'b0; pr_set = 1'b0; pr_addr = r_vid[VW-1:0];
        case (r_state)
            S_IDLE: begin
                n_ov = 1'b0;
                if (i_valid) begin
                    n_kind  = i_kind;
                    n_vid   = i_vertex_id;
                    n_nw    = i_new_weight;
                    n_inr   = (32'(i_vertex_id) < VERTEX_COUNT);
                    p_addr  = i_vertex_id[VW-1:0];
                    n_idx   = '0;
                    n_state = S_RD_POS;
                end
            end
            S_RD_POS: begin
                // extract reads slot 0, others the vertex's slot
                n_idx   = (r_kind == K_EXTRACT) ? '0 : IW'(r_pos);
                s_addr  = (r_kind == K_EXTRACT) ? '0 : r_pos;
                n_state = S_RD_SLOT;
            end
            S_RD_SLOT: n_state = S_DECIDE;
            S_DECIDE: begin
                n_st = ST_OK; n_ovx = r_vid; n_ow = '0;
                n_state = S_OUT;
                case (r_kind)
                    K_INSERT: begin
                        if (cap_full) n_st = ST_OVERFLOW;
                        else if (!r_inr) n_st = ST_ABSENT;
                        else if (cur_present) begin
                            n_st = ST_IGNORED; n_ow = r_rd_w;
                        end else begin
                            n_ow = r_nw; n_cv = r_vid; n_cw = r_nw;
                            n_idx = IW'(r_fill); n_fill = r_fill + NW'(1);
                            pr_we = 1'b1; pr_set = 1'b1;
                            s_we = 1'b1; s_addr = r_fill[SW-1:0];
                            s_wv = r_vid; s_ww = r_nw;
                            p_we = 1'b1; p_wd = r_fill[SW-1:0];
                            n_state = S_UP_RD;
                        end
                    end
                    K_DECREASE: begin
                        if (!cur_present) n_st = ST_ABSENT;
                        else if (r_nw < r_rd_w) begin
                            n_ow = r_nw; n_cv = r_vid; n_cw = r_nw;
                            s_we = 1'b1; s_wv = r_vid; s_ww = r_nw;
                            n_state = S_UP_RD;
                        end else begin
                            n_st = ST_IGNORED; n_ow = r_rd_w;
                        end
                    end
                    K_EXTRACT, K_DELETE: begin
                        if (r_kind == K_EXTRACT && r_fill == '0) begin
                            n_st = ST_EMPTY; n_ovx = '0;
                        end else if (r_kind == K_DELETE && !cur_present) begin
                            n_st = ST_ABSENT;
                        end else begin
                            n_ovx = r_rd_v; n_ow = r_rd_w;
                            pr_we = 1'b1; pr_addr = r_rd_v[VW-1:0];
                            n_fill = r_fill - NW'(1);
                            if (r_idx == last_i) n_state = S_OUT;
                            else begin
                                s_addr = last_i[SW-1:0];
                                n_state = S_LAST_RD;
                            end
                        end
                    end
                    default: begin
                        if (!cur_present) n_st = ST_ABSENT;
                        else n_ow = r_rd_w;
                    end
                endcase
            end
            S_LAST_RD: begin
                // fill count already dropped, so it names the old last slot
                s_addr  = r_fill[SW-1:0];
                n_state = S_LAST_WR;
            end
            S_LAST_WR: begin
                // last entry fills the hole, then sifts up, or down if it does not move up
                n_cv = r_rd_v; n_cw = r_rd_w;
                s_we = 1'b1; s_wv = r_rd_v; s_ww = r_rd_w;
                p_we = 1'b1; p_addr = r_rd_v[VW-1:0];
                n_ov = 1'b1;
                n_state = S_UP_RD;
            end
            S_UP_RD: begin
                n_oth = pidx; s_addr = pidx[SW-1:0];
                if (r_idx == '0) n_state = r_ov ? S_DN_RDL : S_OUT;
                else n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (r_rd_w > r_cw) begin
                    // parent moves down into r_idx, entry goes up
                    s_we = 1'b1; s_wv = r_rd_v; s_ww = r_rd_w;
                    p_we = 1'b1; p_addr = r_rd_v[VW-1:0];
                    n_idx = r_oth; n_ov = 1'b0;
                    n_state = S_UP_WR_ENTRY;
                end else n_state = r_ov ? S_DN_RDL : S_OUT;
            end
            S_UP_WR_ENTRY: begin
                s_we = 1'b1; p_we = 1'b1; p_addr = r_cv[VW-1:0];
                n_state = S_UP_RD;
            end
            S_DN_RDL: begin
                s_addr = lidx[SW-1:0];
                if (HW'(lidx) >= HW'(r_fill)) n_state = S_OUT;
                else n_state = S_DN_RDR;
            end
            S_DN_RDR: begin
                n_lv = r_rd_v; n_lw = r_rd_w; n_oth = lidx;
                s_addr = ridx[SW-1:0];
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if ((HW'(ridx) < HW'(r_fill)) && (r_rd_w < r_lw) && (r_rd_w < r_cw)) begin
                    s_we = 1'b1; s_wv = r_rd_v; s_ww = r_rd_w;
                    p_we = 1'b1; p_addr = r_rd_v[VW-1:0];
                    n_idx = ridx;
                    n_state = S_UP_WR_ENTRY;
                end else if (r_lw < r_cw) begin
                    s_we = 1'b1; s_wv = r_lv; s_ww = r_lw;
                    p_we = 1'b1; p_addr = r_lv[VW-1:0];
                    n_idx = r_oth;
                    n_state = S_UP_WR_ENTRY;
                end else n_state = S_OUT;
            end
            S_OUT: begin
                n_op = r_inr && r_present[r_ovx[VW-1:0]] && (32'(r_ovx) < VERTEX_COUNT);
                if (o_valid && !i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // after a down swap the entry write keeps sifting down
        if (r_state == S_UP_WR_ENTRY && r_kind != K_INSERT && r_kind != K_DECREASE
            && r_dn) n_state = S_DN_RDL;
    end

    // down-sift mode flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dn <= 1'b0;
        else if (r_state == S_IDLE) r_dn <= 1'b0;
        else if (r_state == S_DN_RDL) r_dn <= 1'b1;
    end

    // result register valid, set in the cycle after the output state is entered
    logic r_ovld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (r_ovld && !i_stall) r_ovld <= 1'b0;
        else if (r_state == S_OUT && !r_ovld && n_state == S_OUT) r_ovld <= 1'b1;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovld;
    assign o_status      = r_st;
    assign o_out_vertex  = r_ovx;
    assign o_out_weight  = r_ow;
    assign o_is_present  = r_op;
    assign o_entry_count = COUNT_W'(r_fill);

    `IMHQ_ASSERT(a_fill_bound, i_clk, i_rst_n, HW'(r_fill) <= HW'(HEAP_DEPTH), "fill count beyond heap depth")
    `IMHQ_ASSERT_IMP(a_busy_no_out, i_clk, i_rst_n, o_valid, r_state == S_OUT,
        "result valid outside output state")
    `IMHQ_ASSERT_IMP(a_fill_idle, i_clk, i_rst_n, r_state == S_IDLE, $stable(r_fill),
        "fill count moved while idle")
endmodule

@@ test/tb_indexed_min_heap_queue_unit.sv @@
// self-checking testbench for the indexed min-heap queue unit
`timescale 1ns / 1ps

module tb_indexed_min_heap_queue_unit;
    import imhq_pkg::*;

    localparam int DEPTH = 256;
    localparam int WB = 32;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [VERTEX_W-1:0] vtx;
        logic [WB-1:0]       wgt;
        logic                cfg;    // capacity write instead of a request
        logic [COUNT_W-1:0]  cap;
        logic                drain;  // sender waits until all results are back
    } t_req;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VERTEX_W-1:0] vtx;
        logic [WB-1:0]       wgt;
        logic                present;
        logic [COUNT_W-1:0]  count;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [COUNT_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [KIND_W-1:0] i_kind = '0;
    logic [VERTEX_W-1:0] i_vertex_id = '0;
    logic [WB-1:0] i_new_weight = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [VERTEX_W-1:0] o_out_vertex;
    logic [WB-1:0] o_out_weight;
    logic o_is_present;
    logic [COUNT_W-1:0] o_entry_count;

    indexed_min_heap_queue_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_vertex_id(i_vertex_id), .i_new_weight(i_new_weight),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_out_vertex(o_out_vertex), .o_out_weight(o_out_weight),
        .o_is_present(o_is_present), .o_entry_count(o_entry_count)
    );

    always #4 i_clk = ~i_clk;

    // heap mirror
    logic [VERTEX_W-1:0] hv [DEPTH];
    logic [WB-1:0]       hw [DEPTH];
    logic [7:0]          pos [DEPTH];
    logic                live [DEPTH];
    int unsigned         fill;
    int unsigned         cap_reg;

    t_req pending[$];
    t_res expected_results[$];
    int errors = 0;
    int cycles = 0;
    int accepted = 0;
    int results_seen = 0;
    bit stim_done = 0;
    bit quiet = 0;        // no idling on either side
    int hold_cycles = 0;  // long receiver hold-off
    bit hold_done = 0;

    function automatic void put(int s, logic [VERTEX_W-1:0] v, logic [WB-1:0] w);
        hv[s] = v;
        hw[s] = w;
        pos[v] = s[7:0];
    endfunction

    function automatic void swap_entries(int a, int b);
        logic [VERTEX_W-1:0] va;
        logic [WB-1:0] wa;
        va = hv[a];
        wa = hw[a];
        put(a, hv[b], hw[b]);
        put(b, va, wa);
    endfunction

    function automatic int bubble_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (hw[p] > hw[i]) begin
                swap_entries(p, i);
                i = p;
            end else break;
        end
        return i;
    endfunction

    function automatic void bubble_down(int i);
        int l, r, m;
        forever begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            m = i;
            if (l < fill && hw[l] < hw[m]) m = l;
            if (r < fill && hw[r] < hw[m]) m = r;
            if (m == i) break;
            swap_entries(i, m);
            i = m;
        end
    endfunction

    function automatic void take_out(int i);
        int last;
        last = fill - 1;
        live[hv[i]] = 1'b0;
        fill = last;
        if (i != last) begin
            put(i, hv[last], hw[last]);
            bubble_down(bubble_up(i));
        end
    endfunction

    // expected result of one request, updating the mirror
    function automatic t_res heap_result(t_req q);
        t_res r;
        int unsigned lim;
        bit here;
        here = live[q.vtx];
        lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        r.status = ST_OK;
        r.vtx = q.vtx;
        r.wgt = '0;
        case (q.kind)
            K_INSERT: begin
                if (fill >= lim) r.status = ST_OVERFLOW;
                else if (here) begin
                    r.status = ST_IGNORED;
                    r.wgt = hw[pos[q.vtx]];
                end else begin
                    put(fill, q.vtx, q.wgt);
                    fill++;
                    live[q.vtx] = 1'b1;
                    void'(bubble_up(fill - 1));
                    r.wgt = q.wgt;
                end
            end
            K_DECREASE: begin
                if (!here) r.status = ST_ABSENT;
                else if (q.wgt < hw[pos[q.vtx]]) begin
                    hw[pos[q.vtx]] = q.wgt;
                    void'(bubble_up(pos[q.vtx]));
                    r.wgt = q.wgt;
                end else begin
                    r.status = ST_IGNORED;
                    r.wgt = hw[pos[q.vtx]];
                end
            end
            K_EXTRACT: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                    r.vtx = '0;
                end else begin
                    r.vtx = hv[0];
                    r.wgt = hw[0];
                    take_out(0);
                end
            end
            K_DELETE: begin
                if (!here) r.status = ST_ABSENT;
                else begin
                    r.wgt = hw[pos[q.vtx]];
                    take_out(pos[q.vtx]);
                end
            end
            default: begin
                if (!here) r.status = ST_ABSENT;
                else r.wgt = hw[pos[q.vtx]];
            end
        endcase
        r.present = live[r.vtx];
        r.count = fill[COUNT_W-1:0];
        return r;
    endfunction

    function automatic void add_req(logic [KIND_W-1:0] k, logic [VERTEX_W-1:0] v,
                                    logic [WB-1:0] w);
        t_req q;
        q.kind = k; q.vtx = v; q.wgt = w; q.cfg = 0; q.cap = '0; q.drain = 0;
        pending = {pending, q};
    endfunction

    function automatic void add_cap(logic [COUNT_W-1:0] c);
        t_req q;
        q = '{default: '0};
        q.cfg = 1; q.cap = c; q.drain = 1;
        pending = {pending, q};
    endfunction

    function automatic void add_pause();
        t_req q;
        q = '{default: '0};
        q.drain = 1;
        q.kind = K_LOOKUP;
        q.vtx = 8'($urandom_range(0, 255));
        pending = {pending, q};
    endfunction

    function automatic logic [WB-1:0] rand_weight();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: return {WB{1'b1}} - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // stimulus plan
    initial begin
        int n, k, v;
        for (int i = 0; i < DEPTH; i++) live[i] = 0;
        fill = 0;
        cap_reg = 256;
        // directed: every kind, empty heap, extremes, duplicates, ignored decrease
        add_req(K_EXTRACT, 8'd0, '0);
        add_req(K_LOOKUP, 8'd255, '0);
        add_req(K_DECREASE, 8'd7, 32'd1);
        add_req(K_DELETE, 8'd7, '0);
        add_req(K_INSERT, 8'd255, 32'hFFFF_FFFF);
        add_req(K_INSERT, 8'd0, 32'd0);
        add_req(K_INSERT, 8'd170, 32'h5555_5555);
        add_req(K_INSERT, 8'd85, 32'hAAAA_AAAA);
        add_req(K_INSERT, 8'd0, 32'd9);
        add_req(K_DECREASE, 8'd85, 32'hFFFF_FFFF);
        add_req(K_DECREASE, 8'd255, 32'd0);
        add_req(K_LOOKUP, 8'd255, '0);
        add_req(3'd5, 8'd170, '0);
        add_req(3'd6, 8'd1, '0);
        add_req(3'd7, 8'd85, '0);
        add_req(K_DELETE, 8'd170, '0);
        add_req(K_EXTRACT, 8'd0, '0);
        add_req(K_EXTRACT, 8'd0, '0);
        add_req(K_EXTRACT, 8'd0, '0);
        add_req(K_EXTRACT, 8'd0, '0);
        // smallest capacity, overflow and capacity below fill
        add_cap(9'd1);
        add_req(K_INSERT, 8'd3, 32'd4);
        add_req(K_INSERT, 8'd4, 32'd5);
        add_cap(9'd0);
        add_req(K_INSERT, 8'd5, 32'd1);
        add_req(K_EXTRACT, 8'd0, '0);
        // random phases with several capacities
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: add_cap(9'd256);
                1: add_cap(9'd8);
                2: add_cap(9'd511);
                3: add_cap(9'($urandom_range(2, 40)));
                4: add_cap(9'd257);
                default: add_cap(9'd256);
            endcase
            n = 20;
            for (int i = 0; i < n; i++) begin
                k = $urandom_range(0, 99);
                v = (ph == 2 && i < 10) ? $urandom_range(0, 255) : $urandom_range(0, 31);
                if (k < 40) add_req(K_INSERT, 8'(v), rand_weight());
                else if (k < 55) add_req(K_DECREASE, 8'(v), rand_weight());
                else if (k < 75) add_req(K_EXTRACT, 8'($urandom), $urandom);
                else if (k < 87) add_req(K_DELETE, 8'(v), $urandom);
                else add_req(3'($urandom_range(4, 7)), 8'(v), $urandom);
            end
            add_pause();
        end
        // fill the whole heap, then take part of it out
        for (int i = 0; i < 256; i++) add_req(K_INSERT, 8'(i), rand_weight());
        add_req(K_INSERT, 8'd9, 32'd1);
        for (int i = 0; i < 10; i++) add_req(K_DELETE, 8'($urandom_range(0, 255)), '0);
        for (int i = 0; i < 40; i++) add_req(K_EXTRACT, 8'd0, '0);
    end

    // reset
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender: drives at the falling edge
    t_req cur;
    bit busy = 0;
    int settle = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (busy) begin
                // payload held until the transfer
                i_cfg_we <= 1'b0;
            end else if (pending.size() == 0) begin
                i_cfg_we <= 1'b0;
                i_valid <= 1'b0;
                stim_done = 1;
            end else if (pending[0].drain &&
                         (expected_results.size() != 0 || settle < 60)) begin
                i_cfg_we <= 1'b0;
                i_valid <= 1'b0;
                settle = (expected_results.size() != 0) ? 0 : settle + 1;
            end else if (pending[0].cfg) begin
                cur = pending.pop_front();
                settle = 0;
                i_cfg_we <= 1'b1;
                i_cfg_data <= cur.cap;
                cap_reg = cur.cap;
                i_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 27) begin
                i_cfg_we <= 1'b0;
                i_valid <= 1'b0;
            end else begin
                cur = pending.pop_front();
                settle = 0;
                busy = 1;
                i_cfg_we <= 1'b0;
                i_valid <= 1'b1;
                i_kind <= cur.kind;
                i_vertex_id <= cur.vtx;
                i_new_weight <= cur.wgt;
            end
        end
    end

    // receiver stall and idle windows
    always @(negedge i_clk) begin
        if (accepted == 60 && !hold_done) begin
            hold_cycles <= 150;
            hold_done <= 1'b1;
        end else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
        quiet <= (accepted >= 120 && accepted < 200);
        if (hold_cycles > 0 || (accepted == 60 && !hold_done)) i_stall <= 1'b1;
        else i_stall <= !quiet && ($urandom_range(0, 99) < 27);
    end

    // monitor: sample at the rising edge
    always @(posedge i_clk) begin
        t_res got, want, pred;
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && !o_stall) begin
            pred = heap_result(cur);
            expected_results = {expected_results, pred};
            accepted <= accepted + 1;
            busy = 0;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_status, o_out_vertex, o_out_weight, o_is_present, o_entry_count};
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status %0d vertex %0d", $time,
                         got.status, got.vtx);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                end
                if (got.vtx !== want.vtx) begin
                    errors++;
                    $display("%0t: vertex exp %0d got %0d", $time, want.vtx, got.vtx);
                end
                if (got.wgt !== want.wgt) begin
                    errors++;
                    $display("%0t: weight exp %h got %h", $time, want.wgt, got.wgt);
                end
                if (got.present !== want.present) begin
                    errors++;
                    $display("%0t: present exp %b got %b", $time, want.present, got.present);
                end
                if (got.count !== want.count) begin
                    errors++;
                    $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done && expected_results.size() == 0 && !busy);
        repeat (100) @(posedge i_clk);
        $display("%0d requests transferred, %0d results checked", accepted, results_seen);
        $display("covered all kinds, empty and full heap, capacities 0 to 511");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("Simulation FAILED");
        $finish;
    end
endmodule
